FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands used by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition implies a consequence in the same cycle
`define ASSERT_IMPLIES(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

`endif

FILE: rtl/hrp_pkg.sv
// ----------------------------------------------------------------------------
// hrp_pkg
// shared types, constants and helpers of the hex record parser
// ----------------------------------------------------------------------------
package hrp_pkg;

    localparam int POS_W    = 10;
    localparam int OUT_TDATA_W = 56;

    localparam logic [7:0]       CHAR_COLON     = 8'h3A;
    localparam logic [POS_W-1:0] POS_MAX        = 10'd1023;
    // position of the first data byte's low digit; also the shortest line not too short
    localparam logic [POS_W-1:0] FIRST_DATA_POS = 10'd10;
    localparam logic [POS_W-1:0] POS_LEN        = 10'd2;
    localparam logic [POS_W-1:0] POS_ADDR_HI    = 10'd4;
    localparam logic [POS_W-1:0] POS_ADDR_LO    = 10'd6;
    localparam logic [POS_W-1:0] POS_TYPE       = 10'd8;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_EOL  = 1'b1;

    localparam logic RES_DATA   = 1'b0;
    localparam logic RES_FINISH = 1'b1;

    localparam logic [2:0] STATUS_OK        = 3'd0;
    localparam logic [2:0] STATUS_TOO_SHORT = 3'd1;
    localparam logic [2:0] STATUS_NO_COLON  = 3'd2;
    localparam logic [2:0] STATUS_ZERO_LEN  = 3'd3;
    localparam logic [2:0] STATUS_BAD_DIGIT = 3'd4;
    localparam logic [2:0] STATUS_BAD_CKSUM = 3'd5;

    typedef struct packed {
        logic       kind;
        logic [7:0] char_code;
    } item_t;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  data_byte;
        logic [7:0]  byte_index;
        logic [7:0]  record_len;
        logic [15:0] load_address;
        logic [7:0]  record_type;
        logic [2:0]  status;
    } result_t;

    typedef struct packed {
        logic [3:0] value;
        logic       ok;
    } nibble_t;

    // ascii hex digit to value; non-digits decode as zero with ok low
    function automatic nibble_t nibble_of(input logic [7:0] c);
        nibble_t n;
        n.ok    = 1'b1;
        n.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            n.value = c[3:0];
        end
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
        begin
            n.value = c[3:0] + 4'd9;
        end
        else
        begin
            n.ok = 1'b0;
        end
        return n;
    endfunction

endpackage

FILE: rtl/hrp_in_reg.sv
// ----------------------------------------------------------------------------
// hrp_in_reg
// input register of the parser: holds one character or end-of-line item
// ----------------------------------------------------------------------------
module hrp_in_reg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,   // [7:0] char_code
    input  logic          s_tuser,   // [0] kind
    input  logic          take,
    output logic          item_valid,
    output hrp_pkg::item_t item
);
    import hrp_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    assign s_tready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            item_reg.kind      <= s_tuser;
            item_reg.char_code <= s_tdata;
        end
    end

endmodule

FILE: rtl/hrp_decode.sv
// ----------------------------------------------------------------------------
// hrp_decode
// line state and per-character decode: fields, running sum, data bytes
// ----------------------------------------------------------------------------
module hrp_decode (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  hrp_pkg::item_t   item,
    input  logic             res_ready,
    output logic             take,
    output logic             res_load,
    output hrp_pkg::result_t result
);
    import hrp_pkg::*;

    logic [POS_W-1:0] pos_reg,  pos_next;
    logic [3:0]       hi_reg,   hi_next;
    logic [7:0]       sum_reg,  sum_next;
    logic [7:0]       len_reg,  len_next;
    logic [15:0]      addr_reg, addr_next;
    logic [7:0]       type_reg, type_next;
    logic [7:0]       cnt_reg,  cnt_next;
    logic             cks_reg,  cks_next;
    logic [2:0]       err_reg,  err_next;
    logic             produce;

    always_comb
    begin
        logic [POS_W-1:0] last_digit;
        nibble_t          nib;
        logic [7:0]       byte_val;

        last_digit = FIRST_DATA_POS + {1'b0, len_reg, 1'b0};
        nib        = nibble_of(item.char_code);
        byte_val   = {hi_reg, nib.value};

        pos_next  = pos_reg;
        hi_next   = hi_reg;
        sum_next  = sum_reg;
        len_next  = len_reg;
        addr_next = addr_reg;
        type_next = type_reg;
        cnt_next  = cnt_reg;
        cks_next  = cks_reg;
        err_next  = err_reg;
        produce   = 1'b0;

        result.result_kind  = RES_DATA;
        result.data_byte    = byte_val;
        result.byte_index   = cnt_reg;
        result.record_len   = len_reg;
        result.load_address = addr_reg;
        result.record_type  = type_reg;
        result.status       = STATUS_OK;

        if (item.kind == KIND_EOL)
        begin
            produce            = 1'b1;
            result.result_kind = RES_FINISH;
            result.data_byte   = 8'd0;
            if (pos_reg < FIRST_DATA_POS)
                result.status = STATUS_TOO_SHORT;
            else if (err_reg != STATUS_OK)
                result.status = err_reg;
            else if (len_reg == 8'd0)
                result.status = STATUS_ZERO_LEN;
            else if (!cks_reg)
                result.status = STATUS_TOO_SHORT;
            else if (sum_reg != 8'd0)
                result.status = STATUS_BAD_CKSUM;
            else
                result.status = STATUS_OK;
            // back to the start of a line
            pos_next  = '0;
            hi_next   = '0;
            sum_next  = '0;
            len_next  = '0;
            addr_next = '0;
            type_next = '0;
            cnt_next  = '0;
            cks_next  = 1'b0;
            err_next  = STATUS_OK;
        end
        else
        begin
            if (pos_reg != POS_MAX)
                pos_next = pos_reg + 1'b1;
            if (pos_reg == '0)
            begin
                if (item.char_code != CHAR_COLON)
                    err_next = STATUS_NO_COLON;
            end
            else if (pos_reg <= last_digit)
            begin
                if (!nib.ok && err_reg == STATUS_OK)
                    err_next = STATUS_BAD_DIGIT;
                if (pos_reg[0])
                begin
                    hi_next = nib.value;
                end
                else
                begin
                    sum_next = sum_reg + byte_val;
                    if (pos_reg == POS_LEN)
                        len_next = byte_val;
                    else if (pos_reg == POS_ADDR_HI)
                        addr_next = {byte_val, addr_reg[7:0]};
                    else if (pos_reg == POS_ADDR_LO)
                        addr_next = {addr_reg[15:8], byte_val};
                    else if (pos_reg == POS_TYPE)
                        type_next = byte_val;
                    else if (pos_reg == last_digit)
                        cks_next = 1'b1;
                    else
                    begin
                        produce  = 1'b1;
                        cnt_next = cnt_reg + 8'd1;
                    end
                end
            end
        end
    end

    assign take     = item_valid && (!produce || res_ready);
    assign res_load = take && produce;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            hi_reg   <= '0;
            sum_reg  <= '0;
            len_reg  <= '0;
            addr_reg <= '0;
            type_reg <= '0;
            cnt_reg  <= '0;
            cks_reg  <= 1'b0;
            err_reg  <= STATUS_OK;
        end
        else if (take)
        begin
            pos_reg  <= pos_next;
            hi_reg   <= hi_next;
            sum_reg  <= sum_next;
            len_reg  <= len_next;
            addr_reg <= addr_next;
            type_reg <= type_next;
            cnt_reg  <= cnt_next;
            cks_reg  <= cks_next;
            err_reg  <= err_next;
        end
    end

endmodule

FILE: rtl/hrp_out_reg.sv
// ----------------------------------------------------------------------------
// hrp_out_reg
// result register: holds one data byte or finish result until taken
// ----------------------------------------------------------------------------
module hrp_out_reg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                res_load,
    input  hrp_pkg::result_t                    result,
    output logic                                res_ready,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [hrp_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic                                m_tuser
);
    import hrp_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    assign res_ready = !valid_reg || m_tready;
    assign m_tvalid  = valid_reg;
    assign m_tuser   = res_reg.result_kind;
    assign m_tdata   = {5'd0, res_reg.status, res_reg.record_type, res_reg.load_address,
                        res_reg.record_len, res_reg.byte_index, res_reg.data_byte};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            valid_reg <= res_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= result;
        end
    end

endmodule

FILE: rtl/hex_record_parser.sv
// ----------------------------------------------------------------------------
// hex_record_parser
// intel hex line parser fed one character per transfer
// ----------------------------------------------------------------------------
// A text line arrives as character transfers (tuser low) and closes with one
// end-of-line transfer (tuser high, tdata ignored). Position 0 must be ':';
// the hex pairs after it give length, address (high byte first), record type,
// the data bytes and the checksum, all summed into an 8-bit running sum. Each
// data byte leaves as a result (tuser low) as soon as its second digit is in,
// with its index in the record; characters past the checksum are ignored.
// The end-of-line transfer yields one finish result (tuser high) whose status
// is, in priority order: too short (under ten characters), a recorded error
// (no colon, or the first bad hex digit, which decodes as zero), zero length,
// too short (line ended before the checksum), bad checksum, ok. Data bytes are
// sent even on a line that turns out bad. Throughput is one transfer per
// clock unless the result side stalls: the input register feeds a single
// pass of nibble decode and 8-bit add into the result register, so an input
// transfer passes the input register and then the result register before its
// result is valid on the output. The only stall is a result-producing item
// meeting a full result register that is not being drained.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hex_record_parser (
    input  logic                            clk,
    input  logic                            rst_n,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,  // [7:0] char_code
    input  logic                            s_tuser,  // [0] kind: 0 char, 1 end of line
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [7:0] data_byte, [15:8] byte_index, [23:16] record_len,
    // [39:24] load_address, [47:40] record_type, [50:48] status, rest zero
    output logic [hrp_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                            m_tuser   // [0] result_kind: 0 data, 1 finish
);
    import hrp_pkg::*;

    logic    item_valid;
    item_t   item;
    logic    take;
    logic    res_load;
    logic    res_ready;
    result_t result;

    // input register
    hrp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    // line state and decode
    hrp_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .res_ready  (res_ready),
        .take       (take),
        .res_load   (res_load),
        .result     (result)
    );

    // result register
    hrp_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .res_load   (res_load),
        .result     (result),
        .res_ready  (res_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    // a held item that cannot move blocks new input
    `ASSERT_IMPLIES(a_stall_blocks_input, item_valid && !take, !s_tready,
                    "input taken while stalled")
    // a result is only loaded when the result register can take it
    `ASSERT_IMPLIES(a_load_needs_room, res_load, res_ready, "result register overrun")
    // data results carry a zero status
    `ASSERT_IMPLIES(a_data_status_zero, m_tvalid && !m_tuser,
                    m_tdata[50:48] == STATUS_OK, "data result with status")
    // finish status stays within the defined codes
    `ASSERT_ALWAYS(a_status_range,
                   !(m_tvalid && m_tuser) || m_tdata[50:48] <= STATUS_BAD_CKSUM,
                   "undefined status code")

endmodule

FILE: verif/hex_record_parser_tb.sv
// ----------------------------------------------------------------------------
// hex_record_parser_tb
// self-checking bench for the intel hex line parser
// ----------------------------------------------------------------------------
// Feeds text lines one character transfer at a time, each closed by an
// end-of-line transfer. A short table of hand-picked lines comes first. It is
// followed by random records, mostly well formed with random content, plus
// noise, truncated lines, bad digits, missing colons, wrong checksums,
// trailing junk and one line long enough to saturate the position counter.
// A local decoder tracks the line state and predicts every data byte and
// finish status. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module hex_record_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hrp_pkg::*;

    localparam int RANDOM_ITEMS    = 1700;
    localparam int STALL_LIMIT     = 5000;   // cycles with no transfer on either side
    localparam int DRAIN_CYCLES    = 8;      // extra wait after the queue empties, to catch stray results
    localparam int LONG_HOLD       = 400;    // receiver hold-off that backs up the block
    localparam int HOLD_LINE_NO    = 10;
    localparam int PAUSE_LINE_NO   = 20;
    localparam int LONG_LINE_NO    = 30;
    localparam int LONG_LINE_CHARS = 1030;   // past the 1023 saturation point

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [7:0]             s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;

    // one directed row; want is used only where typed is set
    typedef struct {
        item_t   it;
        bit      typed;
        result_t want;
    } row_t;

    row_t    directed_rows[$];
    item_t   line_q[$];
    result_t decoded_q[$];      // predicted results not yet seen on the output

    int mismatches    = 0;
    int burst_left    = 0;      // lines still to send with no gaps
    bit long_hold_req = 0;

    // decoder state of the line in progress
    int         line_pos;
    logic [3:0] pend_nibble;
    logic [7:0] byte_sum;
    logic [7:0] rec_len;
    logic [15:0] rec_addr;
    logic [7:0] rec_type;
    logic [7:0] bytes_out;
    bit         cksum_done;
    logic [2:0] first_err;

    hex_record_parser u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // decoder
    // ------------------------------------------------------------------------

    function automatic logic [3:0] hex_value(input logic [7:0] c, output bit ok);
        ok = 1'b1;
        if (c >= "0" && c <= "9")
        begin
            return 4'(c - "0");
        end
        if (c >= "A" && c <= "F")
        begin
            return 4'(c - "A" + 10);
        end
        if (c >= "a" && c <= "f")
        begin
            return 4'(c - "a" + 10);
        end
        ok = 1'b0;
        return 4'd0;
    endfunction

    function automatic void clear_decoder();
        line_pos    = 0;
        pend_nibble = '0;
        byte_sum    = '0;
        rec_len     = '0;
        rec_addr    = '0;
        rec_type    = '0;
        bytes_out   = '0;
        cksum_done  = 1'b0;
        first_err   = STATUS_OK;
    endfunction

    // advance the line state by one transfer; returns 1 when a result leaves
    function automatic bit decode_item(input item_t it, output result_t res);
        int         p;
        int         last_digit;
        logic [3:0] nib;
        logic [7:0] b;
        bit         ok;
        res        = '0;
        p          = line_pos;
        last_digit = FIRST_DATA_POS + 2 * rec_len;
        res.record_len   = rec_len;
        res.load_address = rec_addr;
        res.record_type  = rec_type;

        if (it.kind == KIND_EOL)
        begin
            res.result_kind = RES_FINISH;
            res.byte_index  = bytes_out;
            // status priority: short line, recorded error, zero length,
            // missing checksum, checksum sum
            if (p < FIRST_DATA_POS)
                res.status = STATUS_TOO_SHORT;
            else if (first_err != STATUS_OK)
                res.status = first_err;
            else if (rec_len == 8'd0)
                res.status = STATUS_ZERO_LEN;
            else if (!cksum_done)
                res.status = STATUS_TOO_SHORT;
            else if (byte_sum != 8'd0)
                res.status = STATUS_BAD_CKSUM;
            else
                res.status = STATUS_OK;
            clear_decoder();
            return 1'b1;
        end

        if (p < POS_MAX)
            line_pos = p + 1;

        if (p == 0)
        begin
            if (it.char_code != CHAR_COLON)
                first_err = STATUS_NO_COLON;
            return 1'b0;
        end
        // anything past the checksum is ignored
        if (p > last_digit)
            return 1'b0;

        nib = hex_value(it.char_code, ok);
        if (!ok && first_err == STATUS_OK)
            first_err = STATUS_BAD_DIGIT;

        if (p % 2 == 1)
        begin
            pend_nibble = nib;
            return 1'b0;
        end

        b        = {pend_nibble, nib};
        byte_sum = byte_sum + b;

        if (p == POS_LEN)
            rec_len = b;
        else if (p == POS_ADDR_HI)
            rec_addr[15:8] = b;
        else if (p == POS_ADDR_LO)
            rec_addr[7:0] = b;
        else if (p == POS_TYPE)
            rec_type = b;
        else if (p == last_digit)
            cksum_done = 1'b1;
        else
        begin
            res.result_kind = RES_DATA;
            res.data_byte   = b;
            res.byte_index  = bytes_out;
            res.status      = STATUS_OK;
            bytes_out       = bytes_out + 8'd1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    function automatic item_t make_item(input logic kind, input logic [7:0] c);
        item_t it;
        it.kind      = kind;
        it.char_code = c;
        return it;
    endfunction

    function automatic result_t finish_rec(input logic [7:0] idx, input logic [7:0] len,
                                           input logic [15:0] addr, input logic [7:0] rtype,
                                           input logic [2:0] st);
        result_t r;
        r.result_kind  = RES_FINISH;
        r.data_byte    = 8'd0;
        r.byte_index   = idx;
        r.record_len   = len;
        r.load_address = addr;
        r.record_type  = rtype;
        r.status       = st;
        return r;
    endfunction

    // hex digit with random letter case
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10)
            return 8'("0" + nib);
        return 8'(($urandom_range(0, 1) == 1 ? "A" : "a") + nib - 10);
    endfunction

    // mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic add_row(input item_t it, input bit typed, input result_t want);
        row_t row;
        row.it    = it;
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_row(make_item(KIND_CHAR, s[i]), 1'b0, '0);
    endtask

    task automatic build_directed();
        // end of line straight after reset
        add_row(make_item(KIND_EOL, 8'h00), 1'b1,
                finish_rec(8'd0, 8'd0, 16'h0000, 8'h00, STATUS_TOO_SHORT));
        // address FFFE and top type, a non-hex digit in the data byte
        add_text(":01FFFEFFgf02");
        add_row(make_item(KIND_EOL, 8'hFF), 1'b1,
                finish_rec(8'd1, 8'h01, 16'hFFFE, 8'hFF, STATUS_BAD_DIGIT));
        // ten characters without the leading colon
        add_text("#000000000");
        add_row(make_item(KIND_EOL, 8'h5A), 1'b1,
                finish_rec(8'd0, 8'd0, 16'h0000, 8'h00, STATUS_NO_COLON));
    endtask

    // fill line_q with one random line; counted is its number of transfers
    task automatic build_line(input int line_no, output int counted);
        logic [7:0]  rec[$];
        logic [7:0]  sum;
        logic [7:0]  c;
        logic [15:0] addr;
        bit          ok;
        bit          is_long;
        int          len;
        int          n;
        int          pad;
        int          r;
        line_q.delete();
        is_long = (line_no == LONG_LINE_NO);
        r       = $urandom_range(0, 99);

        if (!is_long && r < 8)
        begin
            // noise line of raw bytes
            n = $urandom_range(0, 14);
            for (int i = 0; i < n; i++)
            begin
                if (i == 0 && $urandom_range(0, 1) == 1)
                    c = CHAR_COLON;
                else
                    c = 8'($urandom_range(0, 255));
                line_q.push_back(make_item(KIND_CHAR, c));
            end
        end
        else
        begin
            if (is_long)
                len = 255;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 4)
                    len = 0;
                else if (r < 8)
                    len = $urandom_range(9, 40);
                else if (r < 40)
                    len = $urandom_range(5, 8);
                else
                    len = $urandom_range(1, 4);
            end
            addr = 16'($urandom_range(0, 65535));
            rec.push_back(8'(len));
            rec.push_back(addr[15:8]);
            rec.push_back(addr[7:0]);
            rec.push_back(8'($urandom_range(0, 255)));
            repeat (len) rec.push_back(8'($urandom_range(0, 255)));
            sum = '0;
            foreach (rec[i])
                sum = sum + rec[i];
            c = -sum;
            if (!is_long && $urandom_range(0, 9) == 0)
                c = c + 8'($urandom_range(1, 255));
            rec.push_back(c);

            if (!is_long && $urandom_range(0, 19) == 0)
                c = 8'($urandom_range(0, 255));
            else
                c = CHAR_COLON;
            line_q.push_back(make_item(KIND_CHAR, c));
            foreach (rec[i])
            begin
                line_q.push_back(make_item(KIND_CHAR, hex_char(rec[i][7:4])));
                line_q.push_back(make_item(KIND_CHAR, hex_char(rec[i][3:0])));
            end

            if (!is_long)
            begin
                // one non-hex character somewhere in the digits
                if ($urandom_range(0, 19) == 0)
                begin
                    do
                    begin
                        c = 8'($urandom_range(0, 255));
                        void'(hex_value(c, ok));
                    end
                    while (ok);
                    n = $urandom_range(1, line_q.size() - 1);
                    line_q[n].char_code = c;
                end
                // cut the line short
                if ($urandom_range(0, 11) == 0)
                begin
                    n = $urandom_range(0, line_q.size());
                    while (line_q.size() > n)
                        void'(line_q.pop_back());
                end
            end

            if (is_long)
                pad = LONG_LINE_CHARS - line_q.size();
            else if ($urandom_range(0, 9) == 0)
                pad = $urandom_range(1, 5);
            else
                pad = 0;
            repeat (pad) line_q.push_back(make_item(KIND_CHAR, 8'($urandom_range(0, 255))));
        end
        // end-of-line data is don't care
        line_q.push_back(make_item(KIND_EOL, 8'($urandom_range(0, 255))));
        counted = line_q.size();
    endtask

    // offer one item, wait for its transfer, predict, then maybe go idle
    task automatic send_item(input item_t it, input bit typed, input result_t want);
        result_t res;
        bit      got;
        int      gap;
        s_tvalid <= 1'b1;
        s_tdata  <= it.char_code;
        s_tuser  <= it.kind;
        do
            @(posedge clk);
        while (!s_tready);
        got = decode_item(it, res);
        if (got)
            decoded_q.push_back(typed ? want : res);
        gap = (burst_left > 0) ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t %s: expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    task automatic check_result();
        result_t want;
        if (decoded_q.size() == 0)
        begin
            mismatches++;
            $display("%0t unexpected result: expected none actual tuser %0h tdata %0h",
                     $time, m_tuser, m_tdata);
        end
        else
        begin
            want = decoded_q.pop_front();
            check_field("result_kind",  want.result_kind,  m_tuser);
            check_field("data_byte",    want.data_byte,    m_tdata[7:0]);
            check_field("byte_index",   want.byte_index,   m_tdata[15:8]);
            check_field("record_len",   want.record_len,   m_tdata[23:16]);
            check_field("load_address", want.load_address, m_tdata[39:24]);
            check_field("record_type",  want.record_type,  m_tdata[47:40]);
            check_field("status",       want.status,       m_tdata[50:48]);
        end
    endtask

    // ------------------------------------------------------------------------
    // result side: check every transfer, stall at random
    // ------------------------------------------------------------------------
    initial
    begin
        int hold_left;
        int calm_left;
        hold_left = 0;
        calm_left = 0;
        m_tready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                check_result();
            // long hold-off asked by the sender so the block backs up
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (calm_left > 0)
            begin
                calm_left--;
                m_tready <= 1'b1;
            end
            else if ($urandom_range(0, 99) < 4)
            begin
                // stretch with no stalls
                calm_left = $urandom_range(40, 200);
                m_tready <= 1'b1;
            end
            else
            begin
                hold_left = pick_gap();
                m_tready <= (hold_left == 0);
                if (hold_left > 0)
                    hold_left--;
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: too long without any transfer
    // ------------------------------------------------------------------------
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("hex_record_parser: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------------
    // input side: reset, directed table, random lines, drain
    // ------------------------------------------------------------------------
    initial
    begin
        int counted;
        int item_count;
        int line_no;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        clear_decoder();
        build_directed();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].want);

        item_count = 0;
        line_no    = 0;
        while (item_count < RANDOM_ITEMS)
        begin
            if (line_no == HOLD_LINE_NO)
            begin
                // receiver holds off while lines keep coming back to back
                long_hold_req = 1'b1;
                burst_left    = 6;
            end
            if (line_no == PAUSE_LINE_NO)
            begin
                // sender waits for every outstanding result
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (decoded_q.size() != 0)
                    @(posedge clk);
            end
            if (burst_left == 0 && $urandom_range(0, 3) == 0)
                burst_left = 1;
            build_line(line_no, counted);
            foreach (line_q[j])
                send_item(line_q[j], 1'b0, '0);
            if (burst_left > 0)
                burst_left--;
            item_count += counted;
            line_no++;
        end
        s_tvalid <= 1'b0;

        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("hex_record_parser: match");
        else
            $display("hex_record_parser: mismatch");
        $finish;
    end

endmodule
